>>> rtl/ecsm_pkg.sv
// Shared constants, types and codes for the EC scalar multiply unit.
package ecsm_pkg;
  localparam int unsigned FieldBitsDefault  = 16;
  localparam int unsigned ScalarBitsDefault = 16;
  localparam int unsigned CfgWidth          = 16;
  localparam int unsigned CfgIndexWidth     = 1;

  localparam logic [CfgIndexWidth-1:0] RegFieldPrime = 1'b0;
  localparam logic [CfgIndexWidth-1:0] RegCurveA     = 1'b1;

  // Main sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RED_X,
    ST_RED_Y,
    ST_RED_A,
    ST_BIT,
    ST_ADD_CHK,
    ST_DBL_CHK,
    ST_NUM_SQ,
    ST_NUM_3,
    ST_DEN,
    ST_INV_INIT,
    ST_INV_MUL,
    ST_INV_SQ,
    ST_LAM,
    ST_LAM_SQ,
    ST_XA,
    ST_RY,
    ST_COMMIT,
    ST_OUT
  } ecsm_state_t;

  // Multiplier handshake.
  typedef struct packed {
    logic start;
  } ecsm_mul_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ecsm_mul_sts_t;
endpackage

>>> rtl/ecsm_if.sv
// Valid/ready channel interface carrying one payload beat.
interface ecsm_if #(
  parameter int unsigned W = 1
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/ec_point_scalar_multiply_unit.sv
// Top level: EC scalar multiplication, right-to-left double-and-add.
//
// Use: write field_prime (index 0) and curve_a (index 1) on the cfg port
// while idle, then send one beat {point_x, point_y, scalar} on in_ch. One
// beat {result_x, result_y, at_infinity} comes back on out_ch per input.
// Inputs and a are first reduced mod p by a bit-serial remainder unit
// (F = FIELD_BITS). All field arithmetic runs on one bit-serial modular
// multiplier. Each point operation takes up to 2F+4 products, dominated by
// the Fermat inversion (den^(p-2), square and multiply over F exponent bits).
// Latency is longest with every scalar bit and every bit of p-2 set, and
// well under that for sparse scalars or a sparse p-2. p below 3 skips the
// reduction and goes straight to an infinity result; k = 0 still pays the
// input reduction.
// One item is worked at a time; in_ch.ready is high only in idle.
// The result is held in an output register until out_ch takes it; a stalled
// receiver just holds the block in that state. Reset (synchronous) returns
// to idle, drops out valid, and loads p = 11, a = 1.
module ec_point_scalar_multiply_unit
  import ecsm_pkg::*;
#(
  parameter int unsigned FIELD_BITS  = FieldBitsDefault,
  parameter int unsigned SCALAR_BITS = ScalarBitsDefault
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgWidth-1:0]      cfg_data,
  ecsm_if.sink                     in_ch,
  ecsm_if.source                   out_ch
);
  localparam int unsigned F     = FIELD_BITS;
  localparam int unsigned ExpCW = $clog2(F + 1);

  ecsm_state_t state, state_next;

  // Configuration registers.
  logic [F-1:0] field_prime, curve_a;
  always_ff @(posedge clk) begin
    if (rst) begin
      field_prime <= F'(11);
      curve_a     <= F'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegFieldPrime: field_prime <= F'(cfg_data);
        RegCurveA:     curve_a     <= F'(cfg_data);
        default: ;
      endcase
    end
  end

  // Input beat unpacked: {x, y, k}.
  logic [F-1:0]           in_x, in_y;
  logic [SCALAR_BITS-1:0] in_k;
  assign in_x = in_ch.data[2*F+SCALAR_BITS-1 -: F];
  assign in_y = in_ch.data[F+SCALAR_BITS-1 -: F];
  assign in_k = in_ch.data[SCALAR_BITS-1:0];

  // Working registers.
  logic [F-1:0]           p, a_r, bx, by, ax, ay;
  logic                   a_inf, first, is_dbl;
  logic [SCALAR_BITS-1:0] k;
  logic [F-1:0]           raw_x, raw_y;
  logic [F-1:0]           sx, sy, tx, ty; // operands of current point op
  logic [F-1:0]           num, den, t1, lam, rx, ry;
  logic [F-1:0]           inv_acc, inv_b, e;
  logic [ExpCW-1:0]       ecnt;
  logic [F-1:0]           res_x, res_y;
  logic                   res_inf, out_valid;

  // Shared multiplier.
  ecsm_mul_ctl_t mctl;
  ecsm_mul_sts_t msts;
  logic [F-1:0]  ma, mb, mp;
  logic          mul_issued;

  ecsm_modmul #(.FIELD_BITS(F)) u_mul (
    .clk(clk), .rst(rst), .ctl(mctl), .op_a(ma), .op_b(mb),
    .modulus(p), .prod(mp), .sts(msts)
  );

  // Shared remainder unit for input reduction.
  logic         red_start, red_done, red_issued;
  logic [F-1:0] red_val, red_rem;
  ecsm_modred #(.FIELD_BITS(F)) u_red (
    .clk(clk), .rst(rst), .start(red_start), .value(red_val),
    .modulus(p), .rem(red_rem), .done(red_done)
  );

  // Field helpers on reduced operands (all < p).
  function automatic logic [F-1:0] fsub(input logic [F-1:0] u, input logic [F-1:0] v,
                                        input logic [F-1:0] m);
    logic [F:0] d;
    d = {1'b0, u} - {1'b0, v};
    fsub = d[F] ? F'(d + {1'b0, m}) : d[F-1:0];
  endfunction

  function automatic logic [F-1:0] fadd(input logic [F-1:0] u, input logic [F-1:0] v,
                                        input logic [F-1:0] m);
    logic [F:0] s;
    s = {1'b0, u} + {1'b0, v};
    fadd = (s >= {1'b0, m}) ? F'(s - {1'b0, m}) : s[F-1:0];
  endfunction

  logic step_done;
  assign step_done = msts.done;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_ch.valid) state_next = (field_prime < F'(3)) ? ST_OUT : ST_RED_X;
      ST_RED_X:   if (red_done) state_next = ST_RED_Y;
      ST_RED_Y:   if (red_done) state_next = ST_RED_A;
      ST_RED_A:   if (red_done) state_next = ST_BIT;
      ST_BIT: begin
        if (k == '0)         state_next = ST_OUT;
        else if (!first)     state_next = ST_DBL_CHK;
        else if (k[0])       state_next = ST_ADD_CHK;
        else                 state_next = ST_BIT;
      end
      ST_DBL_CHK: state_next = (by == '0) ? ST_BIT : ST_NUM_SQ;
      ST_ADD_CHK: begin
        if (a_inf)                          state_next = ST_BIT;
        else if (ax == bx)                  state_next = (ay != by || ay == '0) ? ST_BIT
                                                                              : ST_NUM_SQ;
        else                                state_next = ST_INV_INIT;
      end
      ST_NUM_SQ:  if (step_done) state_next = ST_NUM_3;
      ST_NUM_3:   state_next = ST_DEN;
      ST_DEN:     state_next = ST_INV_INIT;
      ST_INV_INIT: state_next = ST_INV_MUL;
      ST_INV_MUL: if (!e[0] || step_done) state_next = ST_INV_SQ;
      ST_INV_SQ:  if (step_done) state_next = (ecnt == ExpCW'(1)) ? ST_LAM : ST_INV_MUL;
      ST_LAM:     if (step_done) state_next = ST_LAM_SQ;
      ST_LAM_SQ:  if (step_done) state_next = ST_XA;
      ST_XA:      state_next = ST_RY;
      ST_RY:      if (step_done) state_next = ST_COMMIT;
      ST_COMMIT:  state_next = ST_BIT;
      ST_OUT:     if (out_valid && out_ch.ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: multiplier and reducer operands.
  always_comb begin
    mctl.start = 1'b0;
    ma = '0;
    mb = '0;
    red_start = 1'b0;
    red_val = '0;
    unique case (state)
      ST_RED_X: begin red_start = !red_issued; red_val = raw_x;   end
      ST_RED_Y: begin red_start = !red_issued; red_val = raw_y;   end
      ST_RED_A: begin red_start = !red_issued; red_val = curve_a; end
      ST_NUM_SQ: begin mctl.start = !mul_issued; ma = sx; mb = sx; end
      ST_INV_MUL: begin mctl.start = !mul_issued && e[0]; ma = inv_acc; mb = inv_b; end
      ST_INV_SQ: begin mctl.start = !mul_issued; ma = inv_b; mb = inv_b; end
      ST_LAM:    begin mctl.start = !mul_issued; ma = num; mb = inv_acc; end
      ST_LAM_SQ: begin mctl.start = !mul_issued; ma = lam; mb = lam; end
      ST_RY:     begin mctl.start = !mul_issued; ma = lam; mb = t1; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      mul_issued <= 1'b0;
      red_issued <= 1'b0;
    end else begin
      state <= state_next;
      if (state_next != state) begin
        mul_issued <= 1'b0;
        red_issued <= 1'b0;
      end else begin
        if (mctl.start) mul_issued <= 1'b1;
        if (red_start)  red_issued <= 1'b1;
      end
      if (state == ST_OUT && !out_valid) out_valid <= 1'b1;
      else if (out_valid && out_ch.ready) out_valid <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        p       <= field_prime;
        raw_x   <= in_x;
        raw_y   <= in_y;
        k       <= in_k;
        a_inf   <= 1'b1;
        ax      <= '0;
        ay      <= '0;
        first   <= 1'b1;
      end
      ST_RED_X: if (red_done) bx  <= red_rem;
      ST_RED_Y: if (red_done) by  <= red_rem;
      ST_RED_A: if (red_done) a_r <= red_rem;
      ST_BIT: begin
        if (k != '0) begin
          if (!first) begin
            is_dbl <= 1'b1;
            sx <= bx; sy <= by; tx <= bx; ty <= by;
          end else if (k[0]) begin
            is_dbl <= 1'b0;
            sx <= ax; sy <= ay; tx <= bx; ty <= by;
          end else begin
            k <= k >> 1;
          end
          if (first && !k[0]) first <= 1'b0;
        end
      end
      ST_DBL_CHK: begin
        // Doubling a point with y = 0 gives infinity; base stays unused after.
        first <= 1'b1; // now handle the add half of this bit
        if (by == '0) begin
          // Base becomes infinity: further adds with it change nothing,
          // and doublings stay infinity. Finish: drop remaining bits.
          k <= '0;
        end
      end
      ST_ADD_CHK: begin
        if (a_inf) begin
          a_inf <= 1'b0; ax <= bx; ay <= by;
          k <= k >> 1; first <= 1'b0;
        end else if (ax == bx && (ay != by || ay == '0)) begin
          a_inf <= 1'b1; ax <= '0; ay <= '0;
          k <= k >> 1; first <= 1'b0;
        end else if (ax != bx) begin
          num <= fsub(ty, sy, p);
          den <= fsub(tx, sx, p);
        end
      end
      ST_NUM_SQ: if (step_done) t1 <= mp;
      ST_NUM_3:  num <= fadd(fadd(fadd(t1, t1, p), t1, p), a_r, p);
      ST_DEN:    den <= fadd(sy, sy, p);
      ST_INV_INIT: begin
        inv_acc <= F'(1);
        inv_b   <= den;
        e       <= p - F'(2);
        ecnt    <= ExpCW'(F);
      end
      ST_INV_MUL: if (e[0] && step_done) inv_acc <= mp;
      ST_INV_SQ: if (step_done) begin
        inv_b <= mp;
        e     <= e >> 1;
        ecnt  <= ecnt - 1'b1;
      end
      ST_LAM:    if (step_done) lam <= mp;
      ST_LAM_SQ: if (step_done) rx <= fsub(fsub(mp, sx, p), tx, p);
      ST_XA:     t1 <= fsub(sx, rx, p);
      ST_RY:     if (step_done) ry <= fsub(mp, sy, p);
      ST_COMMIT: begin
        if (is_dbl) begin
          bx <= rx; by <= ry;
          if (!k[0]) k <= k >> 1;
          first <= k[0];
        end else begin
          ax <= rx; ay <= ry; a_inf <= 1'b0;
          k <= k >> 1; first <= 1'b0;
        end
      end
      ST_OUT: if (!out_valid) begin
        res_inf <= a_inf || (p < F'(3));
        res_x   <= (a_inf || p < F'(3)) ? '0 : ax;
        res_y   <= (a_inf || p < F'(3)) ? '0 : ay;
      end
      default: ;
    endcase
  end

  assign in_ch.ready  = (state == ST_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.data  = {res_x, res_y, res_inf};

  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    msts.busy |-> !red_issued || state == ST_RED_X || state == ST_RED_Y ||
                  state == ST_RED_A || !red_done)
    else $error("units overlap");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |=> (out_valid && $stable(res_x) && $stable(res_y)))
    else $error("result changed while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ch.ready)
    else $error("input accepted while busy");
  a_acc_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BIT && !a_inf) |-> (ax < p && ay < p))
    else $error("accumulator not reduced");
endmodule

>>> rtl/ecsm_modmul.sv
// Bit-serial modular multiplier: MSB-first add-and-double, one bit per cycle.
module ecsm_modmul
  import ecsm_pkg::*;
#(
  parameter int unsigned FIELD_BITS = FieldBitsDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ecsm_mul_ctl_t         ctl,
  input  logic [FIELD_BITS-1:0] op_a,
  input  logic [FIELD_BITS-1:0] op_b,
  input  logic [FIELD_BITS-1:0] modulus,
  output logic [FIELD_BITS-1:0] prod,
  output ecsm_mul_sts_t         sts
);
  localparam int unsigned CntW = $clog2(FIELD_BITS + 1);

  logic [FIELD_BITS-1:0] acc, acc_next;
  logic [FIELD_BITS-1:0] mult;
  logic [FIELD_BITS-1:0] shb;
  logic [CntW-1:0]       cnt;
  logic                  busy, done;
  logic [FIELD_BITS:0]   dbl, dbl_r, addv, add_r;

  // acc < p: 2*acc - p once, then + a - p once (a < p).
  always_comb begin
    dbl   = {acc, 1'b0};
    dbl_r = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
    addv  = dbl_r + (shb[FIELD_BITS-1] ? {1'b0, mult} : '0);
    add_r = (addv >= {1'b0, modulus}) ? addv - {1'b0, modulus} : addv;
    acc_next = add_r[FIELD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= CntW'(FIELD_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc  <= '0;
      mult <= op_a;
      shb  <= op_b;
    end else if (busy) begin
      acc <= acc_next;
      shb <= {shb[FIELD_BITS-2:0], 1'b0};
    end
  end

  assign prod     = acc;
  assign sts.busy = busy;
  assign sts.done = done;

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("multiplier done held");
  a_res_lt_p: assert property (@(posedge clk) disable iff (rst)
    (done && modulus != '0 && $stable(modulus)) |-> (acc < modulus))
    else $error("product not reduced");
  a_start_idle: assert property (@(posedge clk) disable iff (rst) ctl.start |-> !busy)
    else $error("multiplier restarted while busy");
endmodule

>>> rtl/ecsm_modred.sv
// Bit-serial modular reduction: restoring remainder, one bit per cycle.
module ecsm_modred
  import ecsm_pkg::*;
#(
  parameter int unsigned FIELD_BITS = FieldBitsDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [FIELD_BITS-1:0] value,
  input  logic [FIELD_BITS-1:0] modulus,
  output logic [FIELD_BITS-1:0] rem,
  output logic                  done
);
  localparam int unsigned CntW = $clog2(FIELD_BITS + 1);

  logic [FIELD_BITS-1:0] r;
  logic [FIELD_BITS-1:0] sh;
  logic [CntW-1:0]       cnt;
  logic                  busy;
  logic [FIELD_BITS:0]   t, t_r;

  always_comb begin
    t   = {r, sh[FIELD_BITS-1]};
    t_r = (t >= {1'b0, modulus}) ? t - {1'b0, modulus} : t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(FIELD_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r  <= '0;
      sh <= value;
    end else if (busy) begin
      r  <= t_r[FIELD_BITS-1:0];
      sh <= {sh[FIELD_BITS-2:0], 1'b0};
    end
  end

  assign rem = r;
endmodule

>>> verif/ecsm_scalar_checker.sv
// Beat monitor, scalar-multiply predictor and result scoreboard for the EC unit.
module ecsm_scalar_checker
  import ecsm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgWidth-1:0]      cfg_data,
  ecsm_if                          in_ch,
  ecsm_if                          out_ch,
  output int                       errors,
  output int                       pending,
  output int                       seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    bit          inf;
  } ec_pt_t;

  logic [15:0] prime_q, coef_a_q;
  ec_pt_t      kp_expected[$];

  function automatic longint unsigned fmul(longint unsigned u, longint unsigned v,
                                           longint unsigned p);
    return ((u % p) * (v % p)) % p;
  endfunction

  function automatic longint unsigned fermat_inv(longint unsigned d, longint unsigned p);
    longint unsigned acc, b, e;
    acc = 1 % p;
    b = d % p;
    e = p - 2;
    while (e != 0) begin
      if (e[0]) acc = fmul(acc, b, p);
      b = fmul(b, b, p);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic ec_pt_t pt_add(ec_pt_t s, ec_pt_t t, longint unsigned p,
                                    longint unsigned a);
    ec_pt_t r;
    longint unsigned num, den, lam, rx, ry;
    r.x = '0;
    r.y = '0;
    r.inf = 1'b1;
    if (s.inf) return t;
    if (t.inf) return s;
    if (s.x == t.x) begin
      // opposite points, or doubling a point on the x axis
      if (s.y != t.y || s.y == 0) return r;
      num = (fmul(3, fmul(s.x, s.x, p), p) + a) % p;
      den = fmul(2, s.y, p);
    end else begin
      num = (t.y + p - s.y) % p;
      den = (t.x + p - s.x) % p;
    end
    lam = fmul(num, fermat_inv(den, p), p);
    rx  = (fmul(lam, lam, p) + 2 * p - s.x - t.x) % p;
    ry  = (fmul(lam, (s.x + p - rx) % p, p) + p - s.y) % p;
    r.x = rx[15:0];
    r.y = ry[15:0];
    r.inf = 1'b0;
    return r;
  endfunction

  function automatic ec_pt_t scalar_mult(logic [15:0] px, logic [15:0] py, logic [15:0] k);
    ec_pt_t base, acc;
    longint unsigned p, a;
    logic [15:0] kk;
    bit first;
    p = prime_q;
    acc.x = '0;
    acc.y = '0;
    acc.inf = 1'b1;
    kk = k;
    first = 1'b1;
    if (p >= 3) begin
      a = coef_a_q % p;
      base.x = 16'(px % p);
      base.y = 16'(py % p);
      base.inf = 1'b0;
      while (kk != 0) begin
        if (!first) base = pt_add(base, base, p, a);
        if (kk[0]) acc = pt_add(acc, base, p, a);
        kk = kk >> 1;
        first = 1'b0;
      end
    end
    if (acc.inf) begin
      acc.x = '0;
      acc.y = '0;
    end
    return acc;
  endfunction

  assign pending = kp_expected.size();

  always @(posedge clk) begin
    ec_pt_t want;
    logic [15:0] gx, gy;
    logic gi;
    if (rst) begin
      prime_q  <= 16'd11;
      coef_a_q <= 16'd1;
      errors   <= 0;
      seen     <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        kp_expected.push_back(scalar_mult(in_ch.data[47:32], in_ch.data[31:16],
                                          in_ch.data[15:0]));
      if (out_ch.valid && out_ch.ready) begin
        {gx, gy, gi} = out_ch.data;
        seen <= seen + 1;
        if (kp_expected.size() == 0) begin
          if (errors < 10) $display("unexpected result beat x=%0d y=%0d inf=%0b", gx, gy, gi);
          errors <= errors + 1;
        end else begin
          want = kp_expected.pop_front();
          if (gx !== want.x || gy !== want.y || gi !== want.inf) begin
            if (errors < 10)
              $display("mismatch: expected x=%0d y=%0d inf=%0b, got x=%0d y=%0d inf=%0b",
                       want.x, want.y, want.inf, gx, gy, gi);
            errors <= errors + 1;
          end
        end
      end
      // config is captured after the prediction above so a same-cycle write takes next beat
      if (cfg_we) begin
        if (cfg_index == RegFieldPrime) prime_q <= cfg_data;
        else if (cfg_index == RegCurveA) coef_a_q <= cfg_data;
      end
    end
  end
endmodule

>>> verif/ec_point_scalar_multiply_unit_test.sv
// Stimulus, configuration phases, watchdog and verdict for the EC scalar multiply unit.
module ec_point_scalar_multiply_unit_test;
  import ecsm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles with no beat on either channel before we give up
  localparam int StallLimit = 200000;

  logic clk = 1'b0;
  logic rst;
  logic                     cfg_we;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CfgWidth-1:0]      cfg_data;
  int errors, pending, seen;
  int sent = 0;
  int phases = 0;
  int idle_cycles = 0;
  int ready_hold = 0;

  ecsm_if #(.W(48)) in_ch ();
  ecsm_if #(.W(33)) out_ch ();

  ec_point_scalar_multiply_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  ecsm_scalar_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch), .errors(errors), .pending(pending), .seen(seen)
  );

  always #1 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(9) == 0) return $urandom_range(200, 20);
    return $urandom_range(3);
  endfunction

  // receiver side: random stalls on the result channel
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      out_ch.ready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(3) == 0) ready_hold <= pick_gap();
    end
  end

  // watchdog on beat activity
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 idle_cycles, pending);
        $display("ec_point_scalar_multiply_unit_test failed");
        $finish;
      end
    end
  end

  // one input beat; valid is always dropped after acceptance, since the block
  // only becomes ready again once idle
  task automatic send_point(logic [15:0] px, logic [15:0] py, logic [15:0] k);
    int gap;
    gap = ($urandom_range(1) == 0) ? 0 : pick_gap();
    repeat (gap + 1) @(posedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data  <= {px, py, k};
    do @(posedge clk); while (!in_ch.ready);
    in_ch.valid <= 1'b0;
    sent++;
  endtask

  // registers change only with nothing in flight; wait on a clock edge first so
  // the checker has logged the last accepted beat
  task automatic set_curve(logic [15:0] p, logic [15:0] a);
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= RegFieldPrime;
    cfg_data  <= p;
    @(posedge clk);
    cfg_index <= RegCurveA;
    cfg_data  <= a;
    @(posedge clk);
    cfg_we <= 1'b0;
    phases++;
  endtask

  // random beats: scalars mostly full width, sometimes tiny so small
  // multiples and point-plus-negative cases on small curves come up
  task automatic random_points(int n);
    logic [15:0] k;
    repeat (n) begin
      case ($urandom_range(3))
        0:       k = 16'($urandom_range(15));
        default: k = 16'($urandom);
      endcase
      send_point(16'($urandom), 16'($urandom), k);
    end
  endtask

  initial begin
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= RegFieldPrime;
    cfg_data     <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed, reset curve p=11 a=1
    send_point(16'd0, 16'd0, 16'd0);          // zero scalar
    send_point(16'd0, 16'd0, 16'd1);
    send_point(16'd0, 16'd0, 16'd2);          // doubling with y zero
    send_point(16'd2, 16'd4, 16'd3);
    send_point(16'd2, 16'd4, 16'd65535);
    send_point(16'd65535, 16'd65535, 16'd65535); // operands above the prime
    send_point(16'd3, 16'd5, 16'd12);
    send_point(16'd5, 16'd0, 16'd3);
    send_point(16'd1, 16'd1, 16'd32768);
    set_curve(16'd65521, 16'd65534);          // largest prime, a above the prime
    send_point(16'd65520, 16'd65520, 16'd65535);
    send_point(16'd0, 16'd1, 16'd5);
    send_point(16'd12345, 16'd0, 16'd2);
    set_curve(16'd2, 16'd0);                  // modulus below three
    send_point(16'd1, 16'd1, 16'd1);
    send_point(16'd65535, 16'd65535, 16'd65535);
    set_curve(16'd0, 16'd65535);
    send_point(16'd7, 16'd7, 16'd7);
    set_curve(16'd1, 16'd1);
    send_point(16'd0, 16'd0, 16'd3);
    set_curve(16'd65535, 16'd65535);          // composite modulus
    send_point(16'd3, 16'd9, 16'd77);
    send_point(16'd0, 16'd65535, 16'd1);

    // random phases across several curves
    set_curve(16'd5, 16'd0);       random_points(14);
    set_curve(16'd11, 16'd1);      random_points(14);
    set_curve(16'd97, 16'd2);      random_points(14);
    set_curve(16'd65521, 16'd0);   random_points(14);
    set_curve(16'd251, 16'd250);   random_points(14);
    set_curve(16'd221, 16'd3);     random_points(10);  // composite
    set_curve(16'd3, 16'd2);       random_points(10);
    set_curve(16'd40961, 16'($urandom)); random_points(10);

    do @(posedge clk); while (pending != 0);
    repeat (50) @(posedge clk);
    $display("covered %0d input beats, %0d results, %0d curve settings", sent, seen, phases);
    $display("mismatches counted: %0d", errors);
    if (errors == 0 && pending == 0) begin
      $display("ec_point_scalar_multiply_unit_test passed");
    end else begin
      $display("ec_point_scalar_multiply_unit_test failed");
    end
    $finish;
  end
endmodule

>>> files.f
rtl/ecsm_pkg.sv
rtl/ecsm_if.sv
rtl/ecsm_modmul.sv
rtl/ecsm_modred.sv
rtl/ec_point_scalar_multiply_unit.sv
verif/ecsm_scalar_checker.sv
verif/ec_point_scalar_multiply_unit_test.sv
